@@ design/lpe_pkg.sv @@
// Shared types and fixed constants for the Legendre polynomial evaluator.
// No dependencies; used by legendre_poly_eval_top and its bench.
package lpe_pkg;

    // Fraction bits carried on the stream ports
    localparam int IO_FRAC = 30;
    localparam int X_W     = 32;
    localparam int ORD_W   = 7;
    localparam int POLY_W  = 32;
    localparam int DER_W   = 43;
    // Integer bits the derivative quotient may reach before clipping
    localparam int QINT_W  = 14;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_MU,
        S_MV,
        S_UPD,
        S_XX,
        S_XP,
        S_NUM,
        S_DIVS,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

endpackage

@@ design/legendre_poly_eval_top.sv @@
// Legendre polynomial evaluator: Pn(x) by three-term recurrence and Pn'(x).
// Depends on lpe_pkg.
// The recurrence runs one step for each order from 2 to n, and the divider forms a
// quotient of QW = 2*FRAC_BITS + 4 + clog2(MAX_ORDER+1) bits (71 at defaults).
// Order 0 skips the recurrence and the derivative; an end point skips the division.
// One multiplier serves every recurrence step (three products each) and the
// derivative terms; a restoring divider yields one quotient
// bit a cycle. One item at a time: s_tready is high only while no item is in work.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
module legendre_poly_eval_top #(
    parameter int MAX_ORDER = 64,
    parameter int FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] order, [38:7] x_value, [39] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] poly_value, [74:32] deriv_value, rest zero
    output logic [1:0]  m_tuser    // [0] deriv_undefined, [1] saturated
);

    localparam int F      = FRAC_BITS;
    localparam int OW     = $clog2(MAX_ORDER + 1);
    localparam int RCW    = $clog2(MAX_ORDER + 2);
    localparam int VW     = F + 5;
    localparam int MW     = F + 3;
    localparam int PW     = 2 * MW;
    localparam int NW     = MW + OW;
    localparam int QW     = NW + F + 1;
    localparam int CW     = $clog2(QW + 1);
    localparam int DW     = F + 2;
    localparam int RW     = F + 2;
    localparam int IO     = lpe_pkg::IO_FRAC;
    localparam int IN_UP  = (F > IO) ? F - IO : 0;
    localparam int IN_DN  = (F < IO) ? IO - F : 0;
    localparam int OUT_UP = (F < IO) ? IO - F : 0;
    localparam int OUT_DN = (F > IO) ? F - IO : 0;
    localparam int IXW    = IO + 1 + IN_UP;
    localparam int PVW    = VW + OUT_UP;
    localparam int EW     = (QW + OUT_UP > 44) ? QW + OUT_UP : 44;

    localparam logic signed [VW-1:0] ONE_V  = VW'(1) <<< F;
    localparam logic signed [VW-1:0] TWO_V  = VW'(2) <<< F;
    localparam logic [MW-1:0]        ONE_M  = MW'(1) << F;
    localparam logic [MW-1:0]        TWO_M  = MW'(2) << F;
    localparam logic [PW-1:0]        HALF_P = (PW'(1) << F) >> 1;
    localparam logic [IXW-1:0]       IN_HALF  = (IXW'(1) << IN_DN) >> 1;
    localparam logic [PVW-1:0]       PV_HALF  = (PVW'(1) << OUT_DN) >> 1;
    localparam logic [QW-1:0]        OUT_HALF = (QW'(1) << OUT_DN) >> 1;
    localparam logic signed [31:0]   X_MAX  = 32'sd1 <<< IO;
    localparam logic [PVW-1:0]       P_LIM  = PVW'(1) << IO;
    localparam logic [EW-1:0]        D_POS  = (EW'(1) << (lpe_pkg::DER_W - 1)) - EW'(1);
    localparam logic [EW-1:0]        D_NEG  = EW'(1) << (lpe_pkg::DER_W - 1);
    localparam logic [lpe_pkg::DER_W-1:0] DER_MAX = {1'b0, {(lpe_pkg::DER_W-1){1'b1}}};
    localparam logic [lpe_pkg::DER_W-1:0] DER_MIN = {1'b1, {(lpe_pkg::DER_W-1){1'b0}}};

    // Reciprocal table: round(2^F / r), entries below two unused
    logic [F-1:0] recip_rom [MAX_ORDER+1];
    for (genvar Rg = 0; Rg <= MAX_ORDER; Rg++) begin : g_rom
        if (Rg < 2) begin : g_lo
            assign recip_rom[Rg] = '0;
        end else begin : g_hi
            assign recip_rom[Rg] =
                F'(((64'(1) << F) + 64'(Rg / 2)) / 64'(Rg));
        end
    end

    lpe_pkg::state_t state_reg, state_next;

    logic [OW-1:0]          n_reg, n_next;
    logic [RCW-1:0]         r_reg, r_next;
    logic signed [VW-1:0]   x_reg, x_next;
    logic signed [VW-1:0]   p0_reg, p0_next;
    logic signed [VW-1:0]   p1_reg, p1_next;
    logic signed [VW-1:0]   acc_reg, acc_next;
    logic signed [DW-1:0]   den_reg, den_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic                   dneg_reg, dneg_next;
    logic [QW-1:0]          quot_reg, quot_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   sat_reg, sat_next;
    logic                   undef_reg, undef_next;
    logic [lpe_pkg::POLY_W-1:0] poly_reg, poly_next;
    logic [lpe_pkg::DER_W-1:0]  deriv_reg, deriv_next;

    // Shared multiplier operands
    logic [MW-1:0]          op_a, op_b;
    logic                   op_neg;
    logic [PW-1:0]          mul_full;
    logic [PW-1:0]          rnd_sum;
    logic [VW-1:0]          rnd_mag;
    logic signed [VW-1:0]   prod_rnd;
    logic [F-1:0]           ri;
    logic signed [VW-1:0]   diff;
    logic signed [VW-1:0]   p2;

    // Input conversion
    logic [lpe_pkg::ORD_W-1:0]  in_order;
    logic signed [31:0]     x30, xc;
    logic                   x_clip, n_clip;
    logic [IXW-1:0]         xin_mag, xsc_mag;
    logic [VW-1:0]          xv_mag;

    // Output conversion
    logic [VW-1:0]          p1_mag;
    logic [PVW-1:0]         pv_mag;
    logic [RW:0]            rem_sh;
    logic [NW-1:0]          q_int;
    logic [QW-1:0]          q_rnd;
    logic [EW-1:0]          d_mag;

    function automatic logic [MW-1:0] mag_of(input logic signed [VW-1:0] v);
        logic [VW-1:0] m;
        m = v[VW-1] ? VW'(-v) : VW'(v);
        return m[MW-1:0];
    endfunction

    assign in_order = s_tdata[6:0];
    assign x30      = s_tdata[38:7];
    assign ri       = recip_rom[r_reg[OW-1:0]];

    // Round a product half away from zero to F fraction bits
    assign mul_full = {{MW{1'b0}}, op_a} * {{MW{1'b0}}, op_b};
    assign rnd_sum  = (prod_reg + HALF_P) >> F;
    assign rnd_mag  = rnd_sum[VW-1:0];
    assign prod_rnd = neg_reg ? -$signed(rnd_mag) : $signed(rnd_mag);
    assign diff     = p0_reg - prod_rnd;
    assign p2       = acc_reg - prod_rnd;

    // Clamp and scale the incoming point
    always_comb begin
        n_clip = (int'(in_order) > MAX_ORDER);
        x_clip = 1'b0;
        xc     = x30;
        if (x30 > X_MAX) begin
            xc     = X_MAX;
            x_clip = 1'b1;
        end else if (x30 < -X_MAX) begin
            xc     = -X_MAX;
            x_clip = 1'b1;
        end
        xin_mag = xc[31] ? IXW'(-xc) : IXW'(xc);
        if (F >= IO) begin
            xsc_mag = xin_mag << IN_UP;
        end else begin
            xsc_mag = (xin_mag + IN_HALF) >> IN_DN;
        end
        xv_mag = VW'(xsc_mag);
    end

    // Scale Pn back to the port format
    always_comb begin
        p1_mag = p1_reg[VW-1] ? VW'(-p1_reg) : VW'(p1_reg);
        if (F >= IO) begin
            pv_mag = (PVW'(p1_mag) + PV_HALF) >> OUT_DN;
        end else begin
            pv_mag = PVW'(p1_mag) << OUT_UP;
        end
    end

    // Divider step and quotient scaling
    assign rem_sh = {rem_reg, quot_reg[QW-1]};
    assign q_int  = quot_reg[QW-1 -: NW];
    always_comb begin
        q_rnd = (quot_reg + QW'(1)) >> 1;
        if (F >= IO) begin
            d_mag = EW'((q_rnd + OUT_HALF) >> OUT_DN);
        end else begin
            d_mag = EW'(q_rnd) << OUT_UP;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpe_pkg::S_IDLE: begin
                if (s_tvalid) state_next = lpe_pkg::S_LOOP;
            end
            lpe_pkg::S_LOOP: begin
                if (r_reg > RCW'(n_reg)) state_next = lpe_pkg::S_XX;
                else                     state_next = lpe_pkg::S_MU;
            end
            lpe_pkg::S_MU:  state_next = lpe_pkg::S_MV;
            lpe_pkg::S_MV:  state_next = lpe_pkg::S_UPD;
            lpe_pkg::S_UPD: state_next = lpe_pkg::S_LOOP;
            lpe_pkg::S_XX: begin
                if (n_reg == '0) state_next = lpe_pkg::S_OUT;
                else             state_next = lpe_pkg::S_XP;
            end
            lpe_pkg::S_XP:  state_next = lpe_pkg::S_NUM;
            lpe_pkg::S_NUM: begin
                if (den_reg <= 0) state_next = lpe_pkg::S_OUT;
                else              state_next = lpe_pkg::S_DIVS;
            end
            lpe_pkg::S_DIVS: state_next = lpe_pkg::S_DIV;
            lpe_pkg::S_DIV: begin
                if (cnt_reg == CW'(1)) state_next = lpe_pkg::S_FIN;
            end
            lpe_pkg::S_FIN: state_next = lpe_pkg::S_OUT;
            lpe_pkg::S_OUT: begin
                if (m_tready) state_next = lpe_pkg::S_IDLE;
            end
            default: state_next = lpe_pkg::S_IDLE;
        endcase
    end

    // Datapath and handshake outputs
    always_comb begin
        s_tready   = (state_reg == lpe_pkg::S_IDLE);
        m_tvalid   = (state_reg == lpe_pkg::S_OUT);
        op_a       = '0;
        op_b       = '0;
        op_neg     = 1'b0;
        n_next     = n_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        acc_next   = acc_reg;
        den_next   = den_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        dneg_next  = dneg_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        undef_next = undef_reg;
        poly_next  = poly_reg;
        deriv_next = deriv_reg;
        case (state_reg)
            // Take a beat: clamp order and point, seed the recurrence
            lpe_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_next     = n_clip ? OW'(MAX_ORDER) : OW'(in_order);
                    x_next     = xc[31] ? -$signed(xv_mag) : $signed(xv_mag);
                    p0_next    = ONE_V;
                    p1_next    = (in_order == '0) ? ONE_V
                               : (xc[31] ? -$signed(xv_mag) : $signed(xv_mag));
                    r_next     = RCW'(2);
                    sat_next   = n_clip | x_clip;
                    undef_next = 1'b0;
                    deriv_next = '0;
                end
            end
            // x * P(r-1)
            lpe_pkg::S_LOOP: begin
                op_a      = mag_of(x_reg);
                op_b      = mag_of(p1_reg);
                op_neg    = x_reg[VW-1] ^ p1_reg[VW-1];
                prod_next = mul_full;
                neg_next  = op_neg;
            end
            // (2 - 1/r) * t
            lpe_pkg::S_MU: begin
                op_a      = TWO_M - MW'(ri);
                op_b      = mag_of(prod_rnd);
                op_neg    = prod_rnd[VW-1];
                prod_next = mul_full;
                neg_next  = op_neg;
            end
            // hold u, form (1 - 1/r) * P(r-2)
            lpe_pkg::S_MV: begin
                acc_next  = prod_rnd;
                op_a      = ONE_M - MW'(ri);
                op_b      = mag_of(p0_reg);
                op_neg    = p0_reg[VW-1];
                prod_next = mul_full;
                neg_next  = op_neg;
            end
            // new term, clamped to [-2, 2]; advance the order
            lpe_pkg::S_UPD: begin
                p0_next = p1_reg;
                if (p2 > TWO_V)       p1_next = TWO_V;
                else if (p2 < -TWO_V) p1_next = -TWO_V;
                else                  p1_next = p2;
                r_next  = r_reg + RCW'(1);
            end
            // emit Pn, start x^2
            lpe_pkg::S_XX: begin
                if (pv_mag > P_LIM) begin
                    poly_next = p1_reg[VW-1] ? -32'(P_LIM) : 32'(P_LIM);
                    sat_next  = 1'b1;
                end else begin
                    poly_next = p1_reg[VW-1] ? -32'(pv_mag) : 32'(pv_mag);
                end
                op_a      = mag_of(x_reg);
                op_b      = mag_of(x_reg);
                prod_next = mul_full;
                neg_next  = 1'b0;
            end
            // denominator 1 - x^2, then x * Pn
            lpe_pkg::S_XP: begin
                den_next  = DW'(ONE_V - prod_rnd);
                op_a      = mag_of(x_reg);
                op_b      = mag_of(p1_reg);
                op_neg    = x_reg[VW-1] ^ p1_reg[VW-1];
                prod_next = mul_full;
                neg_next  = op_neg;
            end
            // numerator magnitude n * |Pn-1 - x Pn|; handle the end points
            lpe_pkg::S_NUM: begin
                op_a      = mag_of(diff);
                op_b      = MW'(n_reg);
                prod_next = mul_full;
                dneg_next = diff[VW-1];
                if (den_reg <= 0) begin
                    undef_next = 1'b1;
                    sat_next   = 1'b1;
                    deriv_next = ((x_reg > 0) || n_reg[0]) ? DER_MAX : DER_MIN;
                end
            end
            lpe_pkg::S_DIVS: begin
                quot_next = {prod_reg[NW-1:0], {(F+1){1'b0}}};
                rem_next  = '0;
                cnt_next  = CW'(QW);
            end
            // one restoring step per cycle
            lpe_pkg::S_DIV: begin
                if (rem_sh >= (RW+1)'(den_reg)) begin
                    rem_next  = RW'(rem_sh - (RW+1)'(den_reg));
                    quot_next = {quot_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next  = RW'(rem_sh);
                    quot_next = {quot_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
            end
            // round, rescale and clip the derivative
            lpe_pkg::S_FIN: begin
                if (|q_int[NW-1:lpe_pkg::QINT_W]) begin
                    sat_next   = 1'b1;
                    deriv_next = dneg_reg ? DER_MIN : DER_MAX;
                end else if (dneg_reg) begin
                    if (d_mag > D_NEG) begin
                        sat_next   = 1'b1;
                        deriv_next = DER_MIN;
                    end else begin
                        deriv_next = -lpe_pkg::DER_W'(d_mag);
                    end
                end else begin
                    if (d_mag > D_POS) begin
                        sat_next   = 1'b1;
                        deriv_next = DER_MAX;
                    end else begin
                        deriv_next = lpe_pkg::DER_W'(d_mag);
                    end
                end
            end
            lpe_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpe_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg     <= n_next;
        r_reg     <= r_next;
        x_reg     <= x_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        acc_reg   <= acc_next;
        den_reg   <= den_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        dneg_reg  <= dneg_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        sat_reg   <= sat_next;
        undef_reg <= undef_next;
        poly_reg  <= poly_next;
        deriv_reg <= deriv_next;
    end

    assign m_tdata = {5'b0, deriv_reg, poly_reg};
    assign m_tuser = {sat_reg, undef_reg};

    // A result beat never overlaps input acceptance
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Undefined derivative always reports saturation
    a_undef_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tuser[1])
        else $error("undefined derivative without saturation flag");

    // Recurrence never runs beyond the clamped order
    a_order_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lpe_pkg::S_MU) |-> (r_reg <= RCW'(n_reg)))
        else $error("recurrence step beyond order");

    // Pn stays within [-1, 1]
    a_poly_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(poly_reg) <= X_MAX && $signed(poly_reg) >= -X_MAX))
        else $error("poly_value out of range");

    // Divider runs exactly its bit count before finishing
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lpe_pkg::S_FIN) |-> $past(cnt_reg) == CW'(1))
        else $error("divider finished early");

endmodule

@@ bench/legendre_poly_eval_top_tb.sv @@
// Self-checking bench for legendre_poly_eval_top: directed table, then random beats.
// Results are checked against typed rows or a bit-exact predictor of Pn(x), Pn'(x).
// Depends on lpe_pkg and legendre_poly_eval_top.
module legendre_poly_eval_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_ORD    = 64;
    localparam int     N_RANDOM   = 1400;
    localparam int     IDLE_LIMIT = 20000;
    localparam int     HOLD_LEN   = 3000;
    localparam longint ONE        = longint'(1) << lpe_pkg::IO_FRAC;
    localparam longint DMAX       = (longint'(1) << (lpe_pkg::DER_W - 1)) - 1;
    localparam longint DMIN       = -(longint'(1) << (lpe_pkg::DER_W - 1));

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

    typedef struct packed {
        logic [lpe_pkg::POLY_W-1:0] poly;
        logic [lpe_pkg::DER_W-1:0]  deriv;
        logic                       undef;
        logic                       sat;
    } lpe_res_t;

    typedef struct {
        logic [lpe_pkg::ORD_W-1:0] ord;
        logic [lpe_pkg::X_W-1:0]   x;
        bit                        typed;
        lpe_res_t                  res;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [79:0]        m_tdata;
    logic [1:0]         m_tuser;

    // Typed expectation travels beside the beat it belongs to
    logic               row_typed = 1'b0;
    lpe_res_t           row_res = '0;

    lpe_res_t           pending_res[$];
    phase_t             phase = PH_FREE;
    bit                 hold_req = 0;
    int                 err_cnt = 0;
    int                 idle_cycles = 0;

    legendre_poly_eval_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Product rounded half away from zero to the fraction width
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] m;
        m = {64'd0, mag(a)} * {64'd0, mag(b)};
        m = (m + (128'd1 << (lpe_pkg::IO_FRAC - 1))) >> lpe_pkg::IO_FRAC;
        return ((a < 0) != (b < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi, inout bit sat);
        if (v < lo) begin
            sat = 1;
            return lo;
        end
        if (v > hi) begin
            sat = 1;
            return hi;
        end
        return v;
    endfunction

    function automatic lpe_res_t legendre_eval(logic [lpe_pkg::ORD_W-1:0] ord,
                                               logic [lpe_pkg::X_W-1:0] xr);
        int unsigned  n;
        bit           sat, undef, dummy;
        longint       x, p0, p1, p2, ri, den, num, dio, pio;
        logic [63:0]  nm, q;
        logic [127:0] qq;
        lpe_res_t     res;
        n = ord;
        sat = 0;
        undef = 0;
        dio = 0;
        if (n > MAX_ORD) begin
            n = MAX_ORD;
            sat = 1;
        end
        x = clip(longint'(signed'(xr)), -ONE, ONE, sat);
        p0 = ONE;
        p1 = (n == 0) ? ONE : x;
        // Three-term recurrence, each value held within [-2, 2]
        for (int unsigned r = 2; r <= n; r++) begin
            ri = (ONE + r / 2) / r;
            p2 = fx_mul(2 * ONE - ri, fx_mul(x, p1)) - fx_mul(ONE - ri, p0);
            dummy = 0;
            p2 = clip(p2, -2 * ONE, 2 * ONE, dummy);
            p0 = p1;
            p1 = p2;
        end
        pio = clip(p1, -ONE, ONE, sat);
        if (n >= 1) begin
            den = ONE - fx_mul(x, x);
            num = longint'(n) * (p0 - fx_mul(x, p1));
            if (den <= 0) begin
                // End point: saturate with the sign of the true limit
                undef = 1;
                sat = 1;
                dio = ((x > 0) || n[0]) ? DMAX : DMIN;
            end else begin
                nm = mag(num);
                q = nm / 64'(den);
                if (q >= (64'd1 << lpe_pkg::QINT_W)) begin
                    sat = 1;
                    dio = (num < 0) ? DMIN : DMAX;
                end else begin
                    qq = ({64'd0, nm} << (lpe_pkg::IO_FRAC + 1)) / {64'd0, 64'(den)};
                    q = (qq[63:0] + 64'd1) >> 1;
                    dio = (num < 0) ? -longint'(q) : longint'(q);
                    dio = clip(dio, DMIN, DMAX, sat);
                end
            end
        end
        res.poly = pio[lpe_pkg::POLY_W-1:0];
        res.deriv = dio[lpe_pkg::DER_W-1:0];
        res.undef = undef;
        res.sat = sat;
        return res;
    endfunction

    // Record accepted input beats, check result beats, watch for a hang
    always @(posedge aclk) begin
        lpe_res_t exp_r;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_res.push_back(row_typed ? row_res
                                                : legendre_eval(s_tdata[6:0], s_tdata[38:7]));
            end
            if (m_tvalid && m_tready) begin
                if (pending_res.size() == 0) begin
                    $display("%0t: unexpected result beat poly=%h deriv=%h user=%b",
                             $realtime, m_tdata[31:0], m_tdata[74:32], m_tuser);
                    err_cnt++;
                end else begin
                    exp_r = pending_res.pop_front();
                    if (m_tdata[31:0] !== exp_r.poly) begin
                        $display("%0t: poly_value expected %h actual %h",
                                 $realtime, exp_r.poly, m_tdata[31:0]);
                        err_cnt++;
                    end
                    if (m_tdata[74:32] !== exp_r.deriv) begin
                        $display("%0t: deriv_value expected %h actual %h",
                                 $realtime, exp_r.deriv, m_tdata[74:32]);
                        err_cnt++;
                    end
                    if (m_tuser[0] !== exp_r.undef) begin
                        $display("%0t: deriv_undefined expected %b actual %b",
                                 $realtime, exp_r.undef, m_tuser[0]);
                        err_cnt++;
                    end
                    if (m_tuser[1] !== exp_r.sat) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $realtime, exp_r.sat, m_tuser[1]);
                        err_cnt++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $realtime);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result side: stall by phase, or hold off for a long stretch on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            if (phase == PH_SNK_STALL)
                m_tready <= ($urandom_range(99) >= 49);
            else if (phase == PH_BOTH)
                m_tready <= ($urandom_range(99) >= 7);
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_beat(logic [lpe_pkg::ORD_W-1:0] ord, logic [lpe_pkg::X_W-1:0] x,
                             bit typed, lpe_res_t res);
        int gap_pct;
        gap_pct = (phase == PH_SRC_IDLE) ? 49 : (phase == PH_BOTH) ? 7 : 0;
        // Drop valid for a random gap before the beat
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, x, ord};
        row_typed <= typed;
        row_res <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [lpe_pkg::X_W-1:0] rand_point();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) return lpe_pkg::X_W'($urandom_range(32'h8000_0000) - 32'h4000_0000);
        if (sel < 78) return ($urandom_range(1)) ? 32'h4000_0000 : 32'hC000_0000;
        if (sel < 86) return ($urandom_range(1)) ? 32'h4000_0000 - $urandom_range(1000)
                                                 : 32'hC000_0000 + $urandom_range(1000);
        if (sel < 90) return lpe_pkg::X_W'($urandom_range(2000) - 1000);
        return $urandom;
    endfunction

    initial begin
        stim_row_t rows[] = '{
            '{7'd0,   32'h0000_0000, 1, '{32'h4000_0000, 43'd0, 1'b0, 1'b0}},
            '{7'd0,   32'h4000_0000, 1, '{32'h4000_0000, 43'd0, 1'b0, 1'b0}},
            '{7'd0,   32'hC000_0000, 1, '{32'h4000_0000, 43'd0, 1'b0, 1'b0}},
            '{7'd1,   32'h0000_0000, 1, '{32'h0000_0000, 43'h0000_4000_0000, 1'b0, 1'b0}},
            '{7'd1,   32'h4000_0000, 1, '{32'h4000_0000, 43'h3FF_FFFF_FFFF, 1'b1, 1'b1}},
            '{7'd1,   32'hC000_0000, 1, '{32'hC000_0000, 43'h3FF_FFFF_FFFF, 1'b1, 1'b1}},
            '{7'd2,   32'hC000_0000, 0, '0},
            '{7'd2,   32'h0000_0000, 0, '0},
            '{7'd3,   32'h2000_0000, 0, '0},
            '{7'd10,  32'h3FFF_FFFF, 0, '0},
            '{7'd5,   32'h8000_0000, 0, '0},
            '{7'd64,  32'h4000_0000, 0, '0},
            '{7'd64,  32'hC000_0000, 0, '0},
            '{7'd64,  32'h0000_0001, 0, '0},
            '{7'd64,  32'hC000_0001, 0, '0},
            '{7'd65,  32'h1234_5678, 0, '0},
            '{7'd127, 32'h0000_0000, 0, '0},
            '{7'd127, 32'h7FFF_FFFF, 0, '0}
        };
        logic [lpe_pkg::ORD_W-1:0] ord;

        // Hold reset, then release
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (rows[i]) send_beat(rows[i].ord, rows[i].x, rows[i].typed, rows[i].res);

        // Random beats over the four idling phases
        for (int i = 0; i < N_RANDOM; i++) begin
            phase = phase_t'((i * 4) / N_RANDOM);
            if (i == 100) hold_req = 1;
            if (i == 700) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_res.size() != 0) @(posedge aclk);
            end
            ord = ($urandom_range(99) < 85) ? lpe_pkg::ORD_W'($urandom_range(MAX_ORD))
                                            : lpe_pkg::ORD_W'($urandom);
            send_beat(ord, rand_point(), 0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain, then let the sequencer settle
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
